// ===== sv/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the line point rasterizer
// Coordinate width plus the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int COORD_W = 6;

    // Limit compare width: one bit more than a coordinate so 64 fits.
    localparam int LIMIT_W = COORD_W + 1;

    typedef logic [COORD_W-1:0] coord_t;

    // Glyph codes
    localparam logic GLYPH_BACKSLASH = 1'b0;
    localparam logic GLYPH_SLASH     = 1'b1;

    typedef struct packed {
        logic load;     // latch a new segment, clear the step state
        logic advance;  // present the current point and step to the next
    } lpr_cmd_t;

    typedef struct packed {
        logic steps_zero;  // coincident endpoints, nothing to emit
        logic last_point;  // the point on display is the second endpoint
    } lpr_status_t;

endpackage

// ===== sv/lpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpr_ctrl: sequencing state machine of the line point rasterizer
// Accepts a segment, checks for an empty segment, then steps the datapath
// once per cycle until the last point has gone out.
// ----------------------------------------------------------------------------
module lpr_ctrl
    import lpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  lpr_status_t status,
    output lpr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = status.steps_zero ? ST_IDLE : ST_RUN;
            end
            ST_RUN:
            begin
                if (status.last_point)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign cmd.load    = start && (state_reg == ST_IDLE);
    assign cmd.advance = (state_reg == ST_RUN);

endmodule

// ===== sv/lpr_datapath.sv =====
// ----------------------------------------------------------------------------
// lpr_datapath: per-axis quotient and remainder stepping
// Holds the segment, walks q = |d|*i/steps per axis by incremental
// remainder update and forms each point with its flags.
// ----------------------------------------------------------------------------
module lpr_datapath
    import lpr_pkg::*;
#(
    parameter int CANVAS_COLUMNS = 64,
    parameter int CANVAS_ROWS    = 32
)
(
    input  logic        clk,
    input  lpr_cmd_t    cmd,
    output lpr_status_t status,
    input  coord_t      x_start,
    input  coord_t      y_start,
    input  coord_t      x_end,
    input  coord_t      y_end,
    output coord_t      point_x,
    output coord_t      point_y,
    output logic        visible,
    output logic        glyph_code,
    output logic        last
);

    localparam logic [LIMIT_W-1:0] COL_LIMIT = LIMIT_W'(CANVAS_COLUMNS);
    localparam logic [LIMIT_W-1:0] ROW_LIMIT = LIMIT_W'(CANVAS_ROWS);

    coord_t x0_reg, y0_reg;
    coord_t adx_reg, ady_reg;
    logic   negx_reg, negy_reg;
    coord_t steps_reg;
    logic   glyph_reg;
    coord_t qx_reg, qy_reg;
    coord_t rx_reg, ry_reg;
    coord_t cnt_reg;

    // Setup arithmetic straight from the input ports
    logic   in_negx, in_negy;
    coord_t in_adx, in_ady;

    assign in_negx = (x_end < x_start);
    assign in_negy = (y_end < y_start);
    assign in_adx  = in_negx ? (x_start - x_end) : (x_end - x_start);
    assign in_ady  = in_negy ? (y_start - y_end) : (y_end - y_start);

    // Remainder step per axis: at most one quotient increment since |d| <= steps
    logic [COORD_W:0] rx_sum, ry_sum;
    logic             x_carry, y_carry;

    assign rx_sum  = {1'b0, rx_reg} + {1'b0, adx_reg};
    assign ry_sum  = {1'b0, ry_reg} + {1'b0, ady_reg};
    assign x_carry = (rx_sum >= {1'b0, steps_reg});
    assign y_carry = (ry_sum >= {1'b0, steps_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x0_reg    <= x_start;
            y0_reg    <= y_start;
            adx_reg   <= in_adx;
            ady_reg   <= in_ady;
            negx_reg  <= in_negx;
            negy_reg  <= in_negy;
            steps_reg <= (in_adx > in_ady) ? in_adx : in_ady;
            glyph_reg <= ((in_adx != '0) && (in_ady != '0) && (in_negx != in_negy))
                         ? GLYPH_SLASH : GLYPH_BACKSLASH;
            qx_reg    <= '0;
            qy_reg    <= '0;
            rx_reg    <= '0;
            ry_reg    <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.advance)
        begin
            qx_reg  <= x_carry ? (qx_reg + 1'b1) : qx_reg;
            qy_reg  <= y_carry ? (qy_reg + 1'b1) : qy_reg;
            rx_reg  <= x_carry ? COORD_W'(rx_sum - {1'b0, steps_reg}) : COORD_W'(rx_sum);
            ry_reg  <= y_carry ? COORD_W'(ry_sum - {1'b0, steps_reg}) : COORD_W'(ry_sum);
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign point_x    = negx_reg ? (x0_reg - qx_reg) : (x0_reg + qx_reg);
    assign point_y    = negy_reg ? (y0_reg - qy_reg) : (y0_reg + qy_reg);
    assign visible    = ({1'b0, point_x} < COL_LIMIT) && ({1'b0, point_y} < ROW_LIMIT);
    assign glyph_code = glyph_reg;
    assign last       = (cnt_reg == steps_reg);

    assign status.steps_zero = (steps_reg == '0);
    assign status.last_point = last;

endmodule

// ===== sv/line_point_rasterizer.sv =====
// ----------------------------------------------------------------------------
// line_point_rasterizer: DDA line rasterizer, one point per cycle
// Emits the points of a segment from its first endpoint to its second.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload
//  -------   --------------   ---------------------------------------------
//  segment   start / busy     x_start, y_start, x_end, y_end
//  point     valid (strobe)   point_x, point_y, visible, glyph_code, last
//
// A segment is taken at a clock edge with start high and busy low.
// It then passes through the setup state, then emits steps+1 points in the run
// state, one per cycle (steps = max(|dx|, |dy|)), at most 64 points in all;
// the per-cycle quotient and remainder update of the datapath sets that pace.
// A segment with coincident endpoints emits nothing and frees the block
// after the setup cycle. busy stays high until the last point has gone out.
// Reset returns the controller to idle; the receiver takes every point in
// the cycle it is shown and never stalls the block.
//
module line_point_rasterizer
    import lpr_pkg::*;
#(
    parameter int CANVAS_COLUMNS = 64,
    parameter int CANVAS_ROWS    = 32
)
(
    input  logic   clk,
    input  logic   rst_n,
    // segment channel
    input  logic   start,
    output logic   busy,
    input  coord_t x_start,
    input  coord_t y_start,
    input  coord_t x_end,
    input  coord_t y_end,
    // point channel
    output logic   valid,
    output coord_t point_x,
    output coord_t point_y,
    output logic   visible,
    output logic   glyph_code,
    output logic   last
);

    lpr_cmd_t    cmd;
    lpr_status_t status;

    // Sequence: idle, setup (drop empty segments), run until the last point
    lpr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Hold the segment and advance both axes each run cycle
    lpr_datapath #(
        .CANVAS_COLUMNS (CANVAS_COLUMNS),
        .CANVAS_ROWS    (CANVAS_ROWS)
    ) u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .status     (status),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .point_x    (point_x),
        .point_y    (point_y),
        .visible    (visible),
        .glyph_code (glyph_code),
        .last       (last)
    );

    // A point is on the ports in every run cycle
    assign valid = cmd.advance;

endmodule

// ===== bench/line_point_rasterizer_tb.sv =====
// ----------------------------------------------------------------------------
// line_point_rasterizer_tb: self-checking bench for the DDA line rasterizer
// Feeds segments through the start/busy handshake and predicts every point
// of each accepted segment with exact per-axis truncating division. Each
// strobed point is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module line_point_rasterizer_tb;
    import lpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CANVAS_COLUMNS = 64;
    localparam int CANVAS_ROWS    = 32;

    // Drain time after the last predicted point, longer than the longest segment runs.
    localparam int DRAIN_CYCLES = 80;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int PHASE_ITEMS  = 25;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
    } segment_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   visible;
        logic   glyph;
        logic   last;
    } point_t;

    logic   clk;
    logic   rst_n   = 1'b0;
    logic   start   = 1'b0;
    coord_t x_start = '0;
    coord_t y_start = '0;
    coord_t x_end   = '0;
    coord_t y_end   = '0;

    logic   busy;
    logic   valid;
    coord_t point_x;
    coord_t point_y;
    logic   visible;
    logic   glyph_code;
    logic   last;

    segment_t segment_queue[$];    // segments waiting to be offered
    point_t   expected_points[$];  // predicted points, oldest first

    int   idle_pct       = 0;      // chance in a hundred of leaving start low
    int   mismatch_count = 0;
    logic seg_accepted   = 1'b0;   // the last rising edge took a segment

    line_point_rasterizer #(
        .CANVAS_COLUMNS (CANVAS_COLUMNS),
        .CANVAS_ROWS    (CANVAS_ROWS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .valid      (valid),
        .point_x    (point_x),
        .point_y    (point_y),
        .visible    (visible),
        .glyph_code (glyph_code),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold reset low at the start, then release it once, on a falling edge.
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case the block hangs or drops points.
    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // Predict every point of a segment. Each axis steps as start + delta*i/steps
    // with division truncated toward zero; coincident endpoints yield nothing.
    function automatic void rasterize_segment(coord_t x0, coord_t y0,
                                              coord_t x1, coord_t y1);
        int     dx;
        int     dy;
        int     steps;
        int     px;
        int     py;
        logic   glyph;
        point_t pt;
        dx    = int'(x1) - int'(x0);
        dy    = int'(y1) - int'(y0);
        steps = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                         : (dy < 0 ? -dy : dy);
        if (steps == 0)
            return;
        // Slash only when the axes run in opposite directions; flat and
        // upright segments count as backslash.
        glyph = ((dx < 0 && dy > 0) || (dx > 0 && dy < 0)) ? GLYPH_SLASH
                                                           : GLYPH_BACKSLASH;
        for (int i = 0; i <= steps; i++)
        begin
            px         = int'(x0) + (dx * i) / steps;
            py         = int'(y0) + (dy * i) / steps;
            pt.x       = coord_t'(px);
            pt.y       = coord_t'(py);
            pt.visible = (px < CANVAS_COLUMNS) && (py < CANVAS_ROWS);
            pt.glyph   = glyph;
            pt.last    = (i == steps);
            expected_points.insert(expected_points.size(), pt);
        end
    endfunction

    function automatic coord_t clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > 63)
            return coord_t'(63);
        return coord_t'(v);
    endfunction

    task automatic add_segment(int x0, int y0, int x1, int y1);
        segment_t seg;
        seg.x0 = coord_t'(x0);
        seg.y0 = coord_t'(y0);
        seg.x1 = coord_t'(x1);
        seg.y1 = coord_t'(y1);
        segment_queue.insert(segment_queue.size(), seg);
    endtask

    // Mix long random segments with short, axis-aligned and coincident ones.
    task automatic add_random_segment();
        segment_t seg;
        int       kind;
        kind   = $urandom_range(99);
        seg.x0 = coord_t'($urandom_range(63));
        seg.y0 = coord_t'($urandom_range(63));
        seg.x1 = coord_t'($urandom_range(63));
        seg.y1 = coord_t'($urandom_range(63));
        if (kind >= 55 && kind < 80)
        begin
            seg.x1 = clamp_coord(int'(seg.x0) + int'($urandom_range(8)) - 4);
            seg.y1 = clamp_coord(int'(seg.y0) + int'($urandom_range(8)) - 4);
        end
        else if (kind >= 80 && kind < 90)
        begin
            if ($urandom_range(1))
                seg.x1 = seg.x0;
            else
                seg.y1 = seg.y0;
        end
        else if (kind >= 90)
        begin
            seg.x1 = seg.x0;
            seg.y1 = seg.y0;
        end
        segment_queue.insert(segment_queue.size(), seg);
    endtask

    // Load one phase of random items at the given idle rate and wait until
    // the driver has handed all of them over.
    task automatic run_phase(int pct);
        idle_pct = pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
            add_random_segment();
        while (segment_queue.size() != 0 || start)
            @(posedge clk);
    endtask

    // Stimulus and end of run.
    initial
    begin
        while (!rst_n)
            @(posedge clk);

        // Directed items: coincident endpoints at both corners, full-length
        // horizontal and vertical runs, all four diagonal directions, steep
        // and shallow segments with negative deltas, a single step, and
        // segments that cross the bottom edge of the canvas.
        add_segment( 0,  0,  0,  0);
        add_segment(63, 63, 63, 63);
        add_segment( 0,  0, 63,  0);
        add_segment(63, 31,  0, 31);
        add_segment(63,  0, 63, 63);
        add_segment( 0, 63,  0,  0);
        add_segment( 0,  0, 63, 63);
        add_segment(63,  0,  0, 63);
        add_segment( 0, 63, 63,  0);
        add_segment(63, 63,  0,  0);
        add_segment(10,  5,  3, 40);
        add_segment(40,  3,  2, 11);
        add_segment( 5,  5,  6,  5);
        add_segment(31, 31, 32, 32);
        add_segment(21, 42, 42, 21);
        add_segment(42, 21, 21, 42);
        add_segment( 1, 62, 62,  1);
        add_segment(50, 33, 50, 30);

        // Idling phases: none, heavy, none again (the receiver cannot stall,
        // so that phase runs back to back), then light.
        run_phase(0);
        run_phase(72);
        run_phase(0);
        run_phase(17);

        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Driver: change inputs on the falling edge. Hold a raised start until the
    // segment is taken; then offer the next item or drop start to idle.
    always @(negedge clk)
    begin : segment_driver
        segment_t seg;
        if (rst_n && (!start || seg_accepted))
        begin
            if (segment_queue.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                seg = segment_queue.pop_front();
                x_start <= seg.x0;
                y_start <= seg.y0;
                x_end   <= seg.x1;
                y_end   <= seg.y1;
                start   <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: sample on the rising edge. Check a strobed point against the
    // oldest prediction first, then record any segment taken at this edge.
    always @(posedge clk)
    begin : point_monitor
        point_t exp_pt;
        if (rst_n)
        begin
            if (valid)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected point (%0d, %0d), none predicted",
                           point_x, point_y);
                    mismatch_count++;
                end
                else
                begin
                    exp_pt = expected_points.pop_front();
                    if (point_x !== exp_pt.x)
                    begin
                        $error("point_x: expected %0d, got %0d", exp_pt.x, point_x);
                        mismatch_count++;
                    end
                    if (point_y !== exp_pt.y)
                    begin
                        $error("point_y: expected %0d, got %0d", exp_pt.y, point_y);
                        mismatch_count++;
                    end
                    if (visible !== exp_pt.visible)
                    begin
                        $error("visible: expected %0b, got %0b", exp_pt.visible, visible);
                        mismatch_count++;
                    end
                    if (glyph_code !== exp_pt.glyph)
                    begin
                        $error("glyph_code: expected %0b, got %0b",
                               exp_pt.glyph, glyph_code);
                        mismatch_count++;
                    end
                    if (last !== exp_pt.last)
                    begin
                        $error("last: expected %0b, got %0b", exp_pt.last, last);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
                rasterize_segment(x_start, y_start, x_end, y_end);
        end
        seg_accepted <= rst_n && start && !busy;
    end

endmodule
